// ===== rtl/binary_to_decimal_ascii_top_defines.svh =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII - assertion macros
// Shared concurrent assertion helpers, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication
`define B2DA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII - package
// Widths, counts and shared types of the digit converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   // input field width and converted bits
   localparam int VALUE_W    = 64;
   localparam int VALUE_BITS = 64;

   // number of decimal digit cells
   localparam int MAX_DIGITS = 20;

   localparam int CHAR_W      = 6;
   localparam int BCD_W       = 4;
   localparam int CNT_W       = $clog2(VALUE_BITS);
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int LEN_W       = $clog2(MAX_DIGITS + 1);

   // ascii '0' kept to the character width
   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

   // control shared by every digit cell
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/b2da_req_if.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII - request channel
// Valid/ready channel carrying one binary value per beat.
// ----------------------------------------------------------------------------
interface b2da_req_if;
   import b2da_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/b2da_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII - response channel
// Valid/ready channel carrying one ascii digit per beat.
// ----------------------------------------------------------------------------
interface b2da_rsp_if;
   import b2da_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// The first digit is registered onto rsp after VALUE_BITS (64) conversion steps;
//   the remaining digits follow one per cycle while rsp.ready does not stall them.
// The conversion is bit-serial through the digit cell chain, one input bit per cycle;
//   no new value is taken until the last digit is handed to the output register.
// A new value is taken while the last digit still waits in the output register.
// Reset (synchronous, active high) returns the controller to idle, rsp empty.
// ----------------------------------------------------------------------------
// Binary to decimal ASCII - top level
// Shifts the binary value through a chain of bcd digit cells, tracks the
// number of significant digits, then emits them as ascii, top digit first.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_top_defines.svh"

module binary_to_decimal_ascii_top (
   input  logic       clock,
   input  logic       reset,
   b2da_req_if.sink   req,
   b2da_rsp_if.source rsp
);
   import b2da_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]  bin_ff, bin_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   cell_ctrl_type          cell_ctrl;
   logic [BCD_W-1:0]       digit_w [MAX_DIGITS];
   logic                   carry_w [MAX_DIGITS];
   logic                   out_free;
   logic                   grow;

   // digit cell chain, lowest digit fed from the binary shift register
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .carry_in  (bin_ff[VALUE_BITS-1]),
            .digit     (digit_w[i]),
            .carry_out (carry_w[i])
         );
      end else begin : g_next
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .carry_in  (carry_w[i-1]),
            .digit     (digit_w[i]),
            .carry_out (carry_w[i])
         );
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   // a carry into the first zero cell adds one significant digit
   assign grow = carry_w[DIGIT_IDX_W'(len_ff - LEN_W'(1))] &&
                 (len_ff != LEN_W'(MAX_DIGITS));

   // next state of controller and output register
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      cell_ctrl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               bin_in          = req.value[VALUE_BITS-1:0];
               cnt_in          = '0;
               len_in          = LEN_W'(1);
               cell_ctrl.clear = 1'b1;
               state_in        = ST_CONV;
            end
         end
         ST_CONV: begin
            cell_ctrl.shift = 1'b1;
            bin_in          = {bin_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in          = cnt_ff + CNT_W'(1);
            len_in          = grow ? len_ff + LEN_W'(1) : len_ff;
            idx_in          = DIGIT_IDX_W'(len_in - LEN_W'(1));
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + CHAR_W'(digit_w[idx_ff]);
               rsp_last_in  = (idx_ff == '0);
               idx_in       = idx_ff - DIGIT_IDX_W'(1);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.digit_char = rsp_char_ff;
   assign rsp.last_digit = rsp_last_ff;

   // checks
   `B2DA_ASSERT_NEXT(a_load_starts_conv, req.valid && req.ready, (state_ff == ST_CONV) && (cnt_ff == '0) && (len_ff == LEN_W'(1)), "accepted beat did not start a conversion")
   `B2DA_ASSERT_SAME(a_len_range, state_ff == ST_CONV || state_ff == ST_EMIT, (len_ff != '0) && (len_ff <= LEN_W'(MAX_DIGITS)), "digit count out of range")
   `B2DA_ASSERT_SAME(a_idx_in_len, state_ff == ST_EMIT, LEN_W'(idx_ff) < len_ff, "emit index beyond significant digits")
   `B2DA_ASSERT_NEXT(a_last_ends_item, (state_ff == ST_EMIT) && out_free && (idx_ff == '0), (state_ff == ST_IDLE) && rsp.valid && rsp.last_digit, "last digit not flagged or item not closed")
   `B2DA_ASSERT_SAME(a_digit_ascii, rsp.valid, (rsp.digit_char >= ASCII_ZERO) && (rsp.digit_char <= ASCII_ZERO + CHAR_W'(9)), "emitted character is not a digit")

endmodule

// ===== rtl/b2da_cell.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII - digit cell
// One bcd digit of the shift-and-add-3 chain: adjusts, shifts in a bit from
// the neighbor below and hands its top bit to the neighbor above.
// ----------------------------------------------------------------------------
module b2da_cell (
   input  logic                  clock,
   input  b2da_pkg::cell_ctrl_type ctrl,
   input  logic                  carry_in,
   output logic [b2da_pkg::BCD_W-1:0] digit,
   output logic                  carry_out
);
   import b2da_pkg::*;

   localparam logic [BCD_W-1:0] ADJ_LIMIT = BCD_W'(5);
   localparam logic [BCD_W-1:0] ADJ_ADD   = BCD_W'(3);

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] adj;

   // add 3 when the digit would reach ten after doubling
   always_comb begin
      adj = (digit_ff >= ADJ_LIMIT) ? digit_ff + ADJ_ADD : digit_ff;
   end

   // clear on load, shift one bit per conversion step
   always_comb begin
      priority if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = {adj[BCD_W-2:0], carry_in};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit     = digit_ff;
   assign carry_out = adj[BCD_W-1];

endmodule
